>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// Included by files that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication under a synchronous reset.
`define BMM_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication under a synchronous reset.
`define BMM_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define BMM_ASSERT_IMP(name, clk, rst, ante, cons)
`define BMM_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

>>> hw/rtl/bmm_pkg.sv
// Shared types and constants of the banked memory mapper.
// No dependencies; imported by the decoder and the top level.
package bmm_pkg;

   localparam int ADDR_W   = 16;
   localparam int DATA_W   = 8;
   localparam int OP_W     = 3;
   localparam int HALF_AW  = 15;   // boot ROM, low RAM, high RAM
   localparam int DISK_AW  = 12;   // disk ROM
   localparam int PLANE_AW = 14;   // one video plane
   localparam int PLANES   = 4;

   localparam logic [1:0]        WINDOW_TOP = 2'b10;   // 0x8000-0xBFFF
   localparam logic [3:0]        DISK_PAGE  = 4'h6;    // 0x6000-0x6FFF
   localparam logic [3:0]        DISK_LIMIT = 4'h0;    // load offset below 0x1000
   localparam logic [DATA_W-1:0] ROM_FILL   = 8'hFF;
   localparam logic [DATA_W-1:0] RAM_FILL   = 8'h00;
   localparam logic [DATA_W-1:0] PLANE_MAP_RESET = 8'h0F;
   localparam logic [DATA_W-1:0] IO_MAP_RESET    = 8'h00;
   localparam int PM_WINDOW  = 4;
   localparam int PM_ALL_RAM = 5;
   localparam int IO_DISK    = 0;

   typedef enum logic [OP_W-1:0] {
      OP_READ      = 3'd0,
      OP_WRITE     = 3'd1,
      OP_IO_MAP    = 3'd2,
      OP_PORTC_MAP = 3'd3,
      OP_LOAD_BOOT = 3'd4,
      OP_LOAD_DISK = 3'd5
   } op_type;

   // Routing of one transaction to the memories and map registers.
   typedef struct packed {
      logic              is_read;
      logic              is_write;
      logic              io_map_wr;
      logic              portc_map_wr;
      logic              video;
      logic              high;
      logic              low;
      logic              disk;
      logic              boot;
      logic [PLANES-1:0] planes;   // active-high plane enables
   } route_type;

endpackage

>>> hw/rtl/bmm_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies; used for every ROM, RAM and video plane.
module bmm_ram #(
   parameter int ADDR_W = 15,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              en,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wr_data,
   output logic [DATA_W-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/bmm_decode.sv
// Address decoder: maps one transaction onto memories and map registers.
// Depends on bmm_pkg.
module bmm_decode (
   input  logic [bmm_pkg::OP_W-1:0]   operation,
   input  logic [bmm_pkg::ADDR_W-1:0] address,
   input  logic [bmm_pkg::DATA_W-1:0] plane_map,
   input  logic [bmm_pkg::DATA_W-1:0] io_map,
   output bmm_pkg::route_type         route
);
   import bmm_pkg::*;

   logic in_window;

   assign in_window = (address[ADDR_W-1 -: 2] == WINDOW_TOP) && plane_map[PM_WINDOW];

   always_comb begin
      route        = '0;
      route.planes = ~plane_map[PLANES-1:0];
      case (op_type'(operation))
         OP_READ: begin
            route.is_read = 1'b1;
            if (in_window) begin
               route.video = 1'b1;
            end else if (address[ADDR_W-1]) begin
               route.high = 1'b1;
            end else if (plane_map[PM_ALL_RAM]) begin
               route.low = 1'b1;
            end else if (io_map[IO_DISK] && (address[ADDR_W-1 -: 4] == DISK_PAGE)) begin
               route.disk = 1'b1;
            end else begin
               route.boot = 1'b1;
            end
         end
         OP_WRITE: begin
            // Writes into ROM space fall through with no target selected.
            route.is_write = 1'b1;
            if (in_window) begin
               route.video = 1'b1;
            end else if (address[ADDR_W-1]) begin
               route.high = 1'b1;
            end else if (plane_map[PM_ALL_RAM]) begin
               route.low = 1'b1;
            end
         end
         OP_IO_MAP: begin
            route.io_map_wr = 1'b1;
         end
         OP_PORTC_MAP: begin
            route.portc_map_wr = 1'b1;
         end
         OP_LOAD_BOOT: begin
            route.is_write = 1'b1;
            route.boot     = !address[ADDR_W-1];
         end
         OP_LOAD_DISK: begin
            route.is_write = 1'b1;
            route.disk     = (address[ADDR_W-1 -: 4] == DISK_LIMIT);
         end
         default: begin
            route.planes = '0;
         end
      endcase
   end

endmodule

>>> hw/rtl/banked_memory_map_with_vram_planes_core.sv
// Top level of the banked memory mapper with four video RAM planes.
// Depends on bmm_pkg, bmm_decode, bmm_ram and assert_macros.svh.

// After reset the block sweeps every memory to its power-on contents,
// one address per cycle in all memories at once; req_stall stays high
// during the sweep. After that it takes one transaction per cycle while
// req_stall is low. Each transaction gives exactly one response.
// The accepting edge performs the memory access (the memories have a
// registered read) and fills stage 1; the output register loads the
// result when it is empty or its response is taken. req_stall also rises
// while a response is held in the output register and the stage behind it
// is full. Writes land in memory at the accepting edge, so a following
// read always sees them. Non-read operations respond with zero.
module banked_memory_map_with_vram_planes_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [bmm_pkg::OP_W-1:0]   req_operation,
   input  logic [bmm_pkg::ADDR_W-1:0] req_address,
   input  logic [bmm_pkg::DATA_W-1:0] req_data,
   input  logic [bmm_pkg::DATA_W-1:0] req_mask,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [bmm_pkg::DATA_W-1:0] rsp_read_data
);
   import bmm_pkg::*;

   `include "assert_macros.svh"

   route_type route;
   route_type s1_route_ff, s1_route_in;
   logic      s1_valid_ff, s1_valid_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [DATA_W-1:0] plane_map_ff, plane_map_in;
   logic [DATA_W-1:0] io_map_ff, io_map_in;
   logic              clear_ff, clear_in;
   logic [HALF_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic accept, out_free, rd_go, wr_go;
   logic s1_held;
   logic [4:0] s1_src;

   logic [DATA_W-1:0] boot_rd, disk_rd, low_rd, high_rd;
   logic [DATA_W-1:0] plane_rd [PLANES];
   logic [DATA_W-1:0] video_and, result;
   logic [DATA_W-1:0] wr_rom, wr_ram;

   bmm_decode u_decode (
      .operation (req_operation),
      .address   (req_address),
      .plane_map (plane_map_ff),
      .io_map    (io_map_ff),
      .route     (route)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_held   = s1_valid_ff && !out_free;
   assign req_stall = clear_ff || s1_held;
   assign accept    = req_valid && !req_stall;
   assign rd_go     = accept && route.is_read;
   assign wr_go     = accept && route.is_write;
   assign wr_rom    = clear_ff ? ROM_FILL : req_data;
   assign wr_ram    = clear_ff ? RAM_FILL : req_data;
   assign s1_src    = {s1_route_ff.video, s1_route_ff.high, s1_route_ff.low,
                       s1_route_ff.disk, s1_route_ff.boot};

   // During the sweep every memory is written at the counter address;
   // the smaller ones simply see their range several times over.
   bmm_ram #(.ADDR_W(HALF_AW), .DATA_W(DATA_W)) u_boot (
      .clock   (clock),
      .en      (clear_ff || ((rd_go || wr_go) && route.boot)),
      .we      (clear_ff || (wr_go && route.boot)),
      .addr    (clear_ff ? clr_cnt_ff : req_address[HALF_AW-1:0]),
      .wr_data (wr_rom),
      .rd_data (boot_rd)
   );

   bmm_ram #(.ADDR_W(DISK_AW), .DATA_W(DATA_W)) u_disk (
      .clock   (clock),
      .en      (clear_ff || ((rd_go || wr_go) && route.disk)),
      .we      (clear_ff || (wr_go && route.disk)),
      .addr    (clear_ff ? clr_cnt_ff[DISK_AW-1:0] : req_address[DISK_AW-1:0]),
      .wr_data (wr_rom),
      .rd_data (disk_rd)
   );

   bmm_ram #(.ADDR_W(HALF_AW), .DATA_W(DATA_W)) u_low (
      .clock   (clock),
      .en      (clear_ff || ((rd_go || wr_go) && route.low)),
      .we      (clear_ff || (wr_go && route.low)),
      .addr    (clear_ff ? clr_cnt_ff : req_address[HALF_AW-1:0]),
      .wr_data (wr_ram),
      .rd_data (low_rd)
   );

   bmm_ram #(.ADDR_W(HALF_AW), .DATA_W(DATA_W)) u_high (
      .clock   (clock),
      .en      (clear_ff || ((rd_go || wr_go) && route.high)),
      .we      (clear_ff || (wr_go && route.high)),
      .addr    (clear_ff ? clr_cnt_ff : req_address[HALF_AW-1:0]),
      .wr_data (wr_ram),
      .rd_data (high_rd)
   );

   for (genvar p = 0; p < PLANES; p++) begin : g_plane
      bmm_ram #(.ADDR_W(PLANE_AW), .DATA_W(DATA_W)) u_plane (
         .clock   (clock),
         .en      (clear_ff || (route.video && (rd_go || (wr_go && route.planes[p])))),
         .we      (clear_ff || (wr_go && route.video && route.planes[p])),
         .addr    (clear_ff ? clr_cnt_ff[PLANE_AW-1:0] : req_address[PLANE_AW-1:0]),
         .wr_data (wr_ram),
         .rd_data (plane_rd[p])
      );
   end

   always_comb begin
      video_and = ROM_FILL;
      for (int p = 0; p < PLANES; p++) begin
         if (s1_route_ff.planes[p]) begin
            video_and = video_and & plane_rd[p];
         end
      end
      result = '0;
      if (s1_route_ff.is_read) begin
         if (s1_route_ff.video) begin
            result = video_and;
         end else if (s1_route_ff.high) begin
            result = high_rd;
         end else if (s1_route_ff.low) begin
            result = low_rd;
         end else if (s1_route_ff.disk) begin
            result = disk_rd;
         end else begin
            result = boot_rd;
         end
      end
   end

   always_comb begin
      s1_route_in  = accept ? route : s1_route_ff;
      s1_valid_in  = accept || s1_held;
      rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;
      rsp_data_in  = (out_free && s1_valid_ff) ? result : rsp_data_ff;
      plane_map_in = plane_map_ff;
      io_map_in    = io_map_ff;
      if (accept && route.portc_map_wr) begin
         plane_map_in = req_data & req_mask;
      end
      if (accept && route.io_map_wr) begin
         io_map_in = req_data;
      end
      clr_cnt_in = clear_ff ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
      clear_in   = clear_ff && (clr_cnt_ff != '1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         plane_map_ff <= PLANE_MAP_RESET;
         io_map_ff    <= IO_MAP_RESET;
         clear_ff     <= 1'b1;
         clr_cnt_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         plane_map_ff <= plane_map_in;
         io_map_ff    <= io_map_in;
         clear_ff     <= clear_in;
         clr_cnt_ff   <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_route_ff <= s1_route_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   `BMM_ASSERT_IMP(a_no_work_in_sweep, clock, reset, clear_ff, !s1_valid_ff && !rsp_valid_ff)
   `BMM_ASSERT_NXT(a_accept_fills_stage, clock, reset, accept, s1_valid_ff)
   `BMM_ASSERT_IMP(a_one_read_source, clock, reset, s1_valid_ff && s1_route_ff.is_read, $onehot(s1_src))
   `BMM_ASSERT_NXT(a_held_stage_keeps, clock, reset, s1_held, s1_valid_ff && $stable(s1_route_ff))

endmodule

>>> dv/tb.sv
// Self-checking testbench for banked_memory_map_with_vram_planes_core.
// Depends on bmm_pkg and the RTL; a behavioral copy of the mapper predicts untyped responses.
// Stimulus is a directed table, then random traffic under three idle-rate settings.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bmm_pkg::*;

   // Operation codes that the block must ignore.
   localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

   localparam int RANDOM_PER_PHASE = 484;
   localparam int LONG_HOLD_CYCLES = 60;
   localparam int LONG_HOLD_AT = 300;
   localparam int MAX_PRINTED = 100;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
      logic [DATA_W-1:0] mask;
      logic              typed;
      logic [DATA_W-1:0] result;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 30;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      {OP_READ,      16'h0000, 8'h00, 8'h00, 1'b1, 8'hFF},
      {OP_READ,      16'hFFFF, 8'h00, 8'h00, 1'b1, 8'h00},
      {OP_READ,      16'h8000, 8'h00, 8'h00, 1'b1, 8'h00},
      {OP_WRITE,     16'h1234, 8'hA5, 8'hFF, 1'b1, 8'h00},
      {OP_READ,      16'h1234, 8'h00, 8'h00, 1'b1, 8'hFF},
      {OP_LOAD_BOOT, 16'h7FFF, 8'h3C, 8'h00, 1'b1, 8'h00},
      {OP_READ,      16'h7FFF, 8'h00, 8'h00, 1'b1, 8'h3C},
      {OP_LOAD_BOOT, 16'h8000, 8'h11, 8'h00, 1'b1, 8'h00},
      {OP_READ,      16'h0000, 8'h00, 8'h00, 1'b1, 8'hFF},
      {OP_LOAD_DISK, 16'h0FFF, 8'h5A, 8'h00, 1'b1, 8'h00},
      {OP_LOAD_DISK, 16'h1000, 8'h77, 8'h00, 1'b1, 8'h00},
      {OP_IO_MAP,    16'h0000, 8'hFF, 8'h00, 1'b1, 8'h00},
      {OP_READ,      16'h6FFF, 8'h00, 8'h00, 1'b1, 8'h5A},
      {OP_READ,      16'h6000, 8'h00, 8'h00, 1'b1, 8'hFF},
      {OP_PORTC_MAP, 16'h0000, 8'hFF, 8'h00, 1'b1, 8'h00},
      {OP_WRITE,     16'h8001, 8'hC3, 8'h00, 1'b0, 8'h00},
      {OP_PORTC_MAP, 16'h0000, 8'hFF, 8'h30, 1'b0, 8'h00},
      {OP_WRITE,     16'h8001, 8'h3C, 8'h00, 1'b0, 8'h00},
      {OP_READ,      16'h8001, 8'h00, 8'h00, 1'b0, 8'h00},
      {OP_WRITE,     16'h0000, 8'h81, 8'h00, 1'b0, 8'h00},
      {OP_READ,      16'h0000, 8'h00, 8'h00, 1'b0, 8'h00},
      {OP_PORTC_MAP, 16'h0000, 8'h1E, 8'hFF, 1'b0, 8'h00},
      {OP_WRITE,     16'hBFFF, 8'h0F, 8'h00, 1'b0, 8'h00},
      {OP_READ,      16'hBFFF, 8'h00, 8'h00, 1'b0, 8'h00},
      {OP_PORTC_MAP, 16'h0000, 8'h1F, 8'hFF, 1'b0, 8'h00},
      {OP_READ,      16'h8001, 8'h00, 8'h00, 1'b1, 8'hFF},
      {OP_UNUSED_HI, 16'hFFFF, 8'hFF, 8'hFF, 1'b1, 8'h00},
      {OP_UNUSED_LO, 16'h0000, 8'h00, 8'h00, 1'b1, 8'h00},
      {OP_PORTC_MAP, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00},
      {OP_READ,      16'h8001, 8'h00, 8'h00, 1'b0, 8'h00}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [OP_W-1:0]   req_operation = '0;
   logic [ADDR_W-1:0] req_address = '0;
   logic [DATA_W-1:0] req_data = '0;
   logic [DATA_W-1:0] req_mask = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [DATA_W-1:0] rsp_read_data;

   banked_memory_map_with_vram_planes_core i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_address   (req_address),
      .req_data      (req_data),
      .req_mask      (req_mask),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_read_data (rsp_read_data)
   );

   // Shadow copy of the mapper's memories and map registers.
   logic [DATA_W-1:0] boot_image  [1 << HALF_AW];
   logic [DATA_W-1:0] disk_image  [1 << DISK_AW];
   logic [DATA_W-1:0] low_ram_img [1 << HALF_AW];
   logic [DATA_W-1:0] high_ram_img[1 << HALF_AW];
   logic [DATA_W-1:0] plane_img   [PLANES << PLANE_AW];
   logic [DATA_W-1:0] plane_map_q;
   logic [DATA_W-1:0] io_map_q;

   logic [DATA_W-1:0] expected_read_data[$];
   logic [DATA_W-1:0] oldest_read;
   int mismatch_count = 0;
   int responses_seen = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_PRINTED)
         $display("ERROR @%0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   function automatic void clear_shadow();
      int i;
      for (i = 0; i < (1 << HALF_AW); i++) begin
         boot_image[i] = ROM_FILL;
         low_ram_img[i] = RAM_FILL;
         high_ram_img[i] = RAM_FILL;
      end
      for (i = 0; i < (1 << DISK_AW); i++) disk_image[i] = ROM_FILL;
      for (i = 0; i < (PLANES << PLANE_AW); i++) plane_img[i] = RAM_FILL;
      plane_map_q = PLANE_MAP_RESET;
      io_map_q = IO_MAP_RESET;
   endfunction

   // Applies one transaction to the shadow state and returns the byte the bus sees.
   function automatic logic [DATA_W-1:0] apply_bus_op(input logic [OP_W-1:0] op,
                                                      input logic [ADDR_W-1:0] a,
                                                      input logic [DATA_W-1:0] d,
                                                      input logic [DATA_W-1:0] m);
      logic [DATA_W-1:0] rd;
      logic              in_window;
      int p;
      rd = '0;
      in_window = (a[15:14] == WINDOW_TOP) && plane_map_q[PM_WINDOW];
      case (op)
         OP_READ: begin
            if (in_window) begin
               // Enabled planes are ANDed; with none enabled the bus floats high.
               rd = 8'hFF;
               for (p = 0; p < PLANES; p++)
                  if (!plane_map_q[p]) rd &= plane_img[{p[1:0], a[PLANE_AW-1:0]}];
            end else if (a[15]) begin
               rd = high_ram_img[a[HALF_AW-1:0]];
            end else if (plane_map_q[PM_ALL_RAM]) begin
               rd = low_ram_img[a[HALF_AW-1:0]];
            end else if (io_map_q[IO_DISK] && a[15:12] == DISK_PAGE) begin
               rd = disk_image[a[DISK_AW-1:0]];
            end else begin
               rd = boot_image[a[HALF_AW-1:0]];
            end
         end
         OP_WRITE: begin
            if (in_window) begin
               for (p = 0; p < PLANES; p++)
                  if (!plane_map_q[p]) plane_img[{p[1:0], a[PLANE_AW-1:0]}] = d;
            end else if (a[15]) begin
               high_ram_img[a[HALF_AW-1:0]] = d;
            end else if (plane_map_q[PM_ALL_RAM]) begin
               low_ram_img[a[HALF_AW-1:0]] = d;
            end
         end
         OP_IO_MAP:    io_map_q = d;
         OP_PORTC_MAP: plane_map_q = d & m;
         OP_LOAD_BOOT: if (!a[15]) boot_image[a[HALF_AW-1:0]] = d;
         OP_LOAD_DISK: if (a[15:12] == DISK_LIMIT) disk_image[a[DISK_AW-1:0]] = d;
         default: ;
      endcase
      return rd;
   endfunction

   // Offers one transaction, waits for it to be taken, and queues its expected response.
   task automatic send_transaction(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] a,
                                   input logic [DATA_W-1:0] d, input logic [DATA_W-1:0] m,
                                   input logic typed, input logic [DATA_W-1:0] typed_result);
      logic [DATA_W-1:0] predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_address <= a;
      req_data <= d;
      req_mask <= m;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = apply_bus_op(op, a, d, m);
      expected_read_data.push_back(typed ? typed_result : predicted);
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      while (expected_read_data.size() != 0) @(posedge clock);
   endtask

   // Half the time a small set of hot addresses, so that reads hit earlier writes and loads.
   task automatic send_random_transaction();
      logic [31:0]       r;
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] a;
      logic [DATA_W-1:0] m;
      int pick;
      r = $urandom;
      if (r[31]) a = r[15:0];
      else a = {r[7:4], 8'h00, r[3:0]};
      pick = $urandom_range(0, 99);
      if (pick < 40) op = OP_READ;
      else if (pick < 68) op = OP_WRITE;
      else if (pick < 73) op = OP_IO_MAP;
      else if (pick < 81) op = OP_PORTC_MAP;
      else if (pick < 89) op = OP_LOAD_BOOT;
      else if (pick < 96) op = OP_LOAD_DISK;
      else if (r[30]) op = OP_UNUSED_HI;
      else op = OP_UNUSED_LO;
      if (op == OP_PORTC_MAP && r[29]) m = 8'hFF;
      else m = DATA_W'($urandom_range(0, 255));
      send_transaction(op, a, DATA_W'($urandom_range(0, 255)), m, 1'b0, 8'h00);
   endtask

   // Response checker and receiver stall generator.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         responses_seen++;
         if (expected_read_data.size() == 0) begin
            report_mismatch($sformatf("response 0x%02h with none expected", rsp_read_data));
         end else begin
            oldest_read = expected_read_data.pop_front();
            if (rsp_read_data !== oldest_read)
               report_mismatch($sformatf("read_data 0x%02h, expected 0x%02h",
                                         rsp_read_data, oldest_read));
         end
      end
      // One long hold-off lets the pipeline back up into the request side.
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && responses_seen >= LONG_HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   initial begin
      int i;
      int n;
      clear_shadow();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // The block sweeps its memories after reset; the first transaction waits on req_stall.
      for (i = 0; i < DIRECTED_ROWS; i++)
         send_transaction(DIRECTED[i].op, DIRECTED[i].addr, DIRECTED[i].data,
                          DIRECTED[i].mask, DIRECTED[i].typed, DIRECTED[i].result);
      pause_until_drained();

      send_idle_pct = 35;
      recv_idle_pct = 52;
      for (i = 0; i < RANDOM_PER_PHASE; i++) send_random_transaction();
      pause_until_drained();

      send_idle_pct = 52;
      recv_idle_pct = 35;
      for (i = 0; i < RANDOM_PER_PHASE; i++) send_random_transaction();
      pause_until_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (i = 0; i < RANDOM_PER_PHASE; i++) send_random_transaction();
      req_valid <= 1'b0;

      for (n = 0; n < 5000 && expected_read_data.size() != 0; n++) @(posedge clock);
      repeat (8) @(posedge clock);
      if (expected_read_data.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", expected_read_data.size()));

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/bmm_pkg.sv
hw/rtl/bmm_ram.sv
hw/rtl/bmm_decode.sv
hw/rtl/banked_memory_map_with_vram_planes_core.sv
dv/tb.sv
